// ===== rtl/core/c8ie_pkg.sv =====
// shared types and constants for the chip8 instruction execute unit
package c8ie_pkg;

    localparam int PC_W   = 12;
    localparam int REG_W  = 8;
    localparam int IDX_W  = 16;
    localparam int NREGS  = 16;
    localparam int RIDX_W = 4;
    localparam int KEYS_W = 16;

    localparam logic [PC_W-1:0]   PC_RESET = 12'h200;
    localparam logic [RIDX_W-1:0] FLAG_REG = 4'hF;

    localparam logic [15:0]      OPC_CLS    = 16'h00E0;
    localparam logic [15:0]      OPC_RET    = 16'h00EE;
    localparam logic [REG_W-1:0] KK_SKP     = 8'h9E;
    localparam logic [REG_W-1:0] KK_SKNP    = 8'hA1;
    localparam logic [REG_W-1:0] KK_LD_VDT  = 8'h07;
    localparam logic [REG_W-1:0] KK_LD_DT   = 8'h15;
    localparam logic [REG_W-1:0] KK_LD_ST   = 8'h18;
    localparam logic [REG_W-1:0] KK_ADD_I   = 8'h1E;

    // top nibble of the instruction
    typedef enum logic [3:0] {
        OP_SYS     = 4'h0,
        OP_JP      = 4'h1,
        OP_CALL    = 4'h2,
        OP_SE_IMM  = 4'h3,
        OP_SNE_IMM = 4'h4,
        OP_SE_REG  = 4'h5,
        OP_LD_IMM  = 4'h6,
        OP_ADD_IMM = 4'h7,
        OP_ALU     = 4'h8,
        OP_SNE_REG = 4'h9,
        OP_LD_I    = 4'hA,
        OP_JP_V0   = 4'hB,
        OP_RND     = 4'hC,
        OP_DRW     = 4'hD,
        OP_KEY     = 4'hE,
        OP_MISC    = 4'hF
    } t_op_class;

    // low nibble of the 8xyn group
    typedef enum logic [3:0] {
        ALU_LD   = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } t_alu_op;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic [IDX_W-1:0]  index_value;
        logic              reg_write_valid;
        logic [RIDX_W-1:0] reg_write_index;
        logic [REG_W-1:0]  reg_write_value;
        logic              flag_write_valid;
        logic              flag_value;
        logic              clear_screen;
        logic              delay_write;
        logic              sound_write;
        logic [REG_W-1:0]  timer_value;
        logic              unhandled;
    } t_result;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] push_pc;
    } t_stack_ctl;

endpackage

// ===== rtl/core/chip8_instruction_execute_unit.sv =====
// chip8 instruction execute unit: input register, execute logic, result register
// an instruction passes the input register, then the result register, before its result is offered
// throughput: one instruction per cycle unless the result side stalls; the register file, pc, index and stack
//   pointer update at the same edge that loads the result, so the next one sees them
// reset: synchronous active low; registers cleared, pc 0x200, stack contents undefined
module chip8_instruction_execute_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // instruction[15:0], random_byte[23:16], keys_down[39:24], delay_value[47:40]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // next_pc[11:0], index_value[27:12], reg_write_valid[28], reg_write_index[32:29],
    // reg_write_value[40:33], flag_write_valid[41], flag_value[42], clear_screen[43],
    // delay_write[44], sound_write[45], timer_value[53:46], unhandled[54], zero[55]
    output logic [55:0] o_m_tdata
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    logic                        r_in_valid;
    logic [15:0]                 r_instr;
    logic [c8ie_pkg::REG_W-1:0]  r_rnd;
    logic [c8ie_pkg::KEYS_W-1:0] r_keys;
    logic [c8ie_pkg::REG_W-1:0]  r_dly;

    logic                        r_out_valid;
    c8ie_pkg::t_result           r_out;

    logic [c8ie_pkg::NREGS-1:0][c8ie_pkg::REG_W-1:0] r_regs;
    logic [c8ie_pkg::PC_W-1:0]   r_pc;
    logic [c8ie_pkg::IDX_W-1:0]  r_index;
    logic [SP_W-1:0]             r_sp;
    logic [SP_W-1:0]             n_sp;
    logic [SP_W-1:0]             rd_addr;
    logic                        r_fwd_valid;
    logic [c8ie_pkg::PC_W-1:0]   r_fwd_pc;
    logic [c8ie_pkg::PC_W-1:0]   ram_rd_data;
    logic [c8ie_pkg::PC_W-1:0]   tos;

    c8ie_pkg::t_result           res;
    c8ie_pkg::t_stack_ctl        stk;
    logic                        exec_fire;
    logic                        push_fire;

    assign exec_fire  = r_in_valid && (!r_out_valid || i_m_tready);
    assign push_fire  = exec_fire && stk.push;
    assign o_s_tready = i_rst_n && (!r_in_valid || exec_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_instr <= i_s_tdata[15:0];
            r_rnd   <= i_s_tdata[23:16];
            r_keys  <= i_s_tdata[39:24];
            r_dly   <= i_s_tdata[47:40];
        end
    end

    // top of stack: the ram holds the entry below the pointer, bypassed right after a push
    assign tos = r_fwd_valid ? r_fwd_pc : ram_rd_data;

    c8ie_exec u_exec (
        .i_instr (r_instr),
        .i_rnd   (r_rnd),
        .i_keys  (r_keys),
        .i_dly   (r_dly),
        .i_regs  (r_regs),
        .i_pc    (r_pc),
        .i_index (r_index),
        .i_tos   (tos),
        .o_res   (res),
        .o_stk   (stk)
    );

    always_comb begin
        n_sp = r_sp;
        if (exec_fire && stk.pop) begin
            n_sp = (r_sp == '0) ? SP_LAST : r_sp - SP_W'(1);
        end else if (push_fire) begin
            n_sp = (r_sp == SP_LAST) ? '0 : r_sp + SP_W'(1);
        end
        rd_addr = (n_sp == '0) ? SP_LAST : n_sp - SP_W'(1);
    end

    c8ie_ram #(
        .WIDTH (c8ie_pkg::PC_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (push_fire),
        .i_wr_addr (r_sp),
        .i_wr_data (stk.push_pc),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs      <= '0;
            r_pc        <= c8ie_pkg::PC_RESET;
            r_index     <= '0;
            r_sp        <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= push_fire;
            r_sp        <= n_sp;
            if (exec_fire) begin
                r_pc    <= res.next_pc;
                r_index <= res.index_value;
                if (res.flag_write_valid) begin
                    r_regs[c8ie_pkg::FLAG_REG] <= {7'b0, res.flag_value};
                end
                if (res.reg_write_valid) begin
                    r_regs[res.reg_write_index] <= res.reg_write_value;
                end
            end
        end
        r_fwd_pc <= stk.push_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (exec_fire) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        1'b0,
        r_out.unhandled,
        r_out.timer_value,
        r_out.sound_write,
        r_out.delay_write,
        r_out.clear_screen,
        r_out.flag_value,
        r_out.flag_write_valid,
        r_out.reg_write_value,
        r_out.reg_write_index,
        r_out.reg_write_valid,
        r_out.index_value,
        r_out.next_pc
    };

endmodule

// ===== rtl/core/c8ie_ram.sv =====
// generic single-write, single-read ram with registered read data
module c8ie_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/c8ie_exec.sv =====
// instruction decode and execute logic, one instruction against the current state
module c8ie_exec (
    input  logic [15:0]                                       i_instr,
    input  logic [c8ie_pkg::REG_W-1:0]                        i_rnd,
    input  logic [c8ie_pkg::KEYS_W-1:0]                       i_keys,
    input  logic [c8ie_pkg::REG_W-1:0]                        i_dly,
    input  logic [c8ie_pkg::NREGS-1:0][c8ie_pkg::REG_W-1:0]   i_regs,
    input  logic [c8ie_pkg::PC_W-1:0]                         i_pc,
    input  logic [c8ie_pkg::IDX_W-1:0]                        i_index,
    input  logic [c8ie_pkg::PC_W-1:0]                         i_tos,
    output c8ie_pkg::t_result                                 o_res,
    output c8ie_pkg::t_stack_ctl                              o_stk
);

    logic [c8ie_pkg::RIDX_W-1:0] x;
    logic [c8ie_pkg::RIDX_W-1:0] y;
    logic [c8ie_pkg::REG_W-1:0]  kk;
    logic [c8ie_pkg::PC_W-1:0]   nnn;
    logic [c8ie_pkg::REG_W-1:0]  vx;
    logic [c8ie_pkg::REG_W-1:0]  vy;
    logic [c8ie_pkg::REG_W:0]    sum;
    logic                        key_hit;
    logic [c8ie_pkg::PC_W-1:0]   pc_adv;

    logic                        skip;
    logic [c8ie_pkg::PC_W-1:0]   pc_new;
    logic [c8ie_pkg::IDX_W-1:0]  index_new;
    logic                        rw;
    logic                        fw;
    logic [c8ie_pkg::REG_W-1:0]  rval;
    logic                        fval;
    logic                        clr;
    logic                        dw;
    logic                        sw;
    logic                        unh;
    logic                        push;
    logic                        pop;

    assign x      = i_instr[11:8];
    assign y      = i_instr[7:4];
    assign kk     = i_instr[7:0];
    assign nnn    = i_instr[11:0];
    assign vx     = i_regs[x];
    assign vy     = i_regs[y];
    assign sum    = {1'b0, vx} + {1'b0, vy};
    assign pc_adv = i_pc + c8ie_pkg::PC_W'(2);
    // keys above the pad never count as pressed
    assign key_hit = (vx[7:4] == 4'h0) && i_keys[vx[3:0]];

    always_comb begin
        skip      = 1'b0;
        pc_new    = pc_adv;
        index_new = i_index;
        rw        = 1'b0;
        fw        = 1'b0;
        rval      = '0;
        fval      = 1'b0;
        clr       = 1'b0;
        dw        = 1'b0;
        sw        = 1'b0;
        unh       = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;

        unique case (c8ie_pkg::t_op_class'(i_instr[15:12]))
            c8ie_pkg::OP_SYS: begin
                if (i_instr == c8ie_pkg::OPC_CLS) begin
                    clr = 1'b1;
                end else if (i_instr == c8ie_pkg::OPC_RET) begin
                    pop    = 1'b1;
                    pc_new = i_tos;
                end else begin
                    unh = 1'b1;
                end
            end
            c8ie_pkg::OP_JP: pc_new = nnn;
            c8ie_pkg::OP_CALL: begin
                push   = 1'b1;
                pc_new = nnn;
            end
            c8ie_pkg::OP_SE_IMM:  skip = (vx == kk);
            c8ie_pkg::OP_SNE_IMM: skip = (vx != kk);
            c8ie_pkg::OP_SE_REG:  skip = (vx == vy);
            c8ie_pkg::OP_LD_IMM: begin
                rw   = 1'b1;
                rval = kk;
            end
            c8ie_pkg::OP_ADD_IMM: begin
                rw   = 1'b1;
                rval = vx + kk;
            end
            c8ie_pkg::OP_ALU: begin
                rw = 1'b1;
                unique case (c8ie_pkg::t_alu_op'(i_instr[3:0]))
                    c8ie_pkg::ALU_LD:  rval = vy;
                    c8ie_pkg::ALU_OR:  rval = vx | vy;
                    c8ie_pkg::ALU_AND: rval = vx & vy;
                    c8ie_pkg::ALU_XOR: rval = vx ^ vy;
                    c8ie_pkg::ALU_ADD: begin
                        fw   = 1'b1;
                        fval = sum[c8ie_pkg::REG_W];
                        rval = sum[c8ie_pkg::REG_W-1:0];
                    end
                    c8ie_pkg::ALU_SUB: begin
                        fw   = 1'b1;
                        fval = (vx > vy);
                        rval = vx - vy;
                    end
                    c8ie_pkg::ALU_SHR: begin
                        fw   = 1'b1;
                        fval = vx[0];
                        rval = {1'b0, vx[7:1]};
                    end
                    c8ie_pkg::ALU_SUBN: begin
                        fw   = 1'b1;
                        fval = (vy > vx);
                        rval = vy - vx;
                    end
                    c8ie_pkg::ALU_SHL: begin
                        fw   = 1'b1;
                        fval = vx[7];
                        rval = {vx[6:0], 1'b0};
                    end
                    default: begin
                        rw  = 1'b0;
                        unh = 1'b1;
                    end
                endcase
            end
            c8ie_pkg::OP_SNE_REG: skip = (vx != vy);
            c8ie_pkg::OP_LD_I:    index_new = {4'h0, nnn};
            c8ie_pkg::OP_JP_V0:   pc_new = {4'h0, i_regs[0]} + nnn;
            c8ie_pkg::OP_RND: begin
                rw   = 1'b1;
                rval = i_rnd & kk;
            end
            c8ie_pkg::OP_DRW: unh = 1'b1;
            c8ie_pkg::OP_KEY: begin
                if (kk == c8ie_pkg::KK_SKP) begin
                    skip = key_hit;
                end else if (kk == c8ie_pkg::KK_SKNP) begin
                    skip = !key_hit;
                end else begin
                    unh = 1'b1;
                end
            end
            c8ie_pkg::OP_MISC: begin
                unique case (kk)
                    c8ie_pkg::KK_LD_VDT: begin
                        rw   = 1'b1;
                        rval = i_dly;
                    end
                    c8ie_pkg::KK_LD_DT: dw = 1'b1;
                    c8ie_pkg::KK_LD_ST: sw = 1'b1;
                    c8ie_pkg::KK_ADD_I: index_new = i_index + {8'h00, vx};
                    default:            unh = 1'b1;
                endcase
            end
        endcase

        // with x as the flag register the vx result is the final vf
        if (fw && (x == c8ie_pkg::FLAG_REG)) begin
            fw   = 1'b0;
            fval = 1'b0;
        end
        if (skip) begin
            pc_new = pc_adv + c8ie_pkg::PC_W'(2);
        end
    end

    always_comb begin
        o_res.next_pc          = pc_new;
        o_res.index_value      = index_new;
        o_res.reg_write_valid  = rw;
        o_res.reg_write_index  = rw ? x : '0;
        o_res.reg_write_value  = rw ? rval : '0;
        o_res.flag_write_valid = fw;
        o_res.flag_value       = fval;
        o_res.clear_screen     = clr;
        o_res.delay_write      = dw;
        o_res.sound_write      = sw;
        o_res.timer_value      = (dw || sw) ? vx : '0;
        o_res.unhandled        = unh;

        o_stk.push    = push;
        o_stk.pop     = pop;
        o_stk.push_pc = pc_adv;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the chip8 instruction execute unit, predictor against stream output
module testbench;
    import c8ie_pkg::*;

    localparam int DEPTH     = 16;
    localparam int MAX_SHOWN = 10;

    localparam logic [3:0] FLAG_OPS [5] = '{ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    always #6 i_clk = ~i_clk;

    chip8_instruction_execute_unit #(.STACK_DEPTH(DEPTH)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // instruction words waiting to go out, executed results waiting to come back
    logic [47:0] pending_instrs [$];
    t_result     expected_results [$];

    // architectural state as the predictor sees it
    logic [7:0]  gp_model [NREGS];
    logic [11:0] pc_model  = PC_RESET;
    logic [15:0] idx_model = '0;
    logic [11:0] stack_model [DEPTH];
    int          sp_model  = 0;

    // stack pointer and written entries as the generator sees them
    int          gen_sp = 0;
    bit          gen_pushed [DEPTH];
    int          queued_count = 0;

    int          instrs_sent   = 0;
    int          results_seen  = 0;
    int          error_count   = 0;
    int          unhandled_cnt = 0;
    int          class_hits [16];

    initial begin
        foreach (gp_model[i]) gp_model[i] = '0;
        foreach (stack_model[i]) stack_model[i] = '0;
        foreach (gen_pushed[i]) gen_pushed[i] = 1'b0;
        foreach (class_hits[i]) class_hits[i] = 0;
    end

    function automatic t_result exec_instr(logic [47:0] word);
        logic [15:0] op, keys;
        logic [7:0]  rnd, dly, vx, vy, kk, rval, tval;
        logic [3:0]  x, y, n;
        logic [11:0] nnn, pc;
        logic [8:0]  sum;
        logic        rw, fw, fval, clr, dw, sw, unh, key_hit;
        t_result     r;
        op   = word[15:0];
        rnd  = word[23:16];
        keys = word[39:24];
        dly  = word[47:40];
        x    = op[11:8];
        y    = op[7:4];
        n    = op[3:0];
        kk   = op[7:0];
        nnn  = op[11:0];
        vx   = gp_model[x];
        vy   = gp_model[y];
        {rw, fw, fval, clr, dw, sw, unh} = '0;
        rval = '0;
        tval = '0;
        pc   = pc_model + 12'd2;
        class_hits[op[15:12]]++;
        case (t_op_class'(op[15:12]))
            OP_SYS: begin
                if (op == OPC_CLS) begin
                    clr = 1'b1;
                end else if (op == OPC_RET) begin
                    sp_model = (sp_model == 0) ? DEPTH - 1 : sp_model - 1;
                    pc = stack_model[sp_model];
                end else begin
                    unh = 1'b1;
                end
            end
            OP_JP:      pc = nnn;
            OP_CALL: begin
                stack_model[sp_model] = pc;
                sp_model = (sp_model + 1) % DEPTH;
                pc = nnn;
            end
            OP_SE_IMM:  if (vx == kk) pc = pc + 12'd2;
            OP_SNE_IMM: if (vx != kk) pc = pc + 12'd2;
            OP_SE_REG:  if (vx == vy) pc = pc + 12'd2;
            OP_LD_IMM: begin
                rw = 1'b1;
                rval = kk;
            end
            OP_ADD_IMM: begin
                rw = 1'b1;
                rval = vx + kk;
            end
            OP_ALU: begin
                rw = 1'b1;
                case (n)
                    ALU_LD:  rval = vy;
                    ALU_OR:  rval = vx | vy;
                    ALU_AND: rval = vx & vy;
                    ALU_XOR: rval = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        fw = 1'b1;
                        fval = sum[8];
                        rval = sum[7:0];
                    end
                    ALU_SUB: begin
                        fw = 1'b1;
                        fval = vx > vy;
                        rval = vx - vy;
                    end
                    ALU_SHR: begin
                        fw = 1'b1;
                        fval = vx[0];
                        rval = vx >> 1;
                    end
                    ALU_SUBN: begin
                        fw = 1'b1;
                        fval = vy > vx;
                        rval = vy - vx;
                    end
                    ALU_SHL: begin
                        fw = 1'b1;
                        fval = vx[7];
                        rval = {vx[6:0], 1'b0};
                    end
                    default: begin
                        rw = 1'b0;
                        unh = 1'b1;
                    end
                endcase
            end
            OP_SNE_REG: if (vx != vy) pc = pc + 12'd2;
            OP_LD_I:    idx_model = {4'h0, nnn};
            OP_JP_V0:   pc = {4'h0, gp_model[0]} + nnn;
            OP_RND: begin
                rw = 1'b1;
                rval = rnd & kk;
            end
            OP_DRW:     unh = 1'b1;
            OP_KEY: begin
                key_hit = (vx < 8'd16) && keys[vx[3:0]];
                if (kk == KK_SKP) begin
                    if (key_hit) pc = pc + 12'd2;
                end else if (kk == KK_SKNP) begin
                    if (!key_hit) pc = pc + 12'd2;
                end else begin
                    unh = 1'b1;
                end
            end
            default: begin
                case (kk)
                    KK_LD_VDT: begin
                        rw = 1'b1;
                        rval = dly;
                    end
                    KK_LD_DT: begin
                        dw = 1'b1;
                        tval = vx;
                    end
                    KK_LD_ST: begin
                        sw = 1'b1;
                        tval = vx;
                    end
                    KK_ADD_I: idx_model = idx_model + {8'h00, vx};
                    default:  unh = 1'b1;
                endcase
            end
        endcase
        // with x = 15 the register write is the final vf
        if (fw && x == FLAG_REG) begin
            fw = 1'b0;
            fval = 1'b0;
        end
        if (fw) gp_model[FLAG_REG] = {7'h00, fval};
        if (rw) gp_model[x] = rval;
        pc_model = pc;
        if (unh) unhandled_cnt++;
        r.next_pc          = pc;
        r.index_value      = idx_model;
        r.reg_write_valid  = rw;
        r.reg_write_index  = rw ? x : 4'h0;
        r.reg_write_value  = rw ? rval : 8'h00;
        r.flag_write_valid = fw;
        r.flag_value       = fval;
        r.clear_screen     = clr;
        r.delay_write      = dw;
        r.sound_write      = sw;
        r.timer_value      = tval;
        r.unhandled        = unh;
        return r;
    endfunction

    function automatic t_result unpack_result(logic [55:0] d);
        t_result r;
        r.next_pc          = d[11:0];
        r.index_value      = d[27:12];
        r.reg_write_valid  = d[28];
        r.reg_write_index  = d[32:29];
        r.reg_write_value  = d[40:33];
        r.flag_write_valid = d[41];
        r.flag_value       = d[42];
        r.clear_screen     = d[43];
        r.delay_write      = d[44];
        r.sound_write      = d[45];
        r.timer_value      = d[53:46];
        r.unhandled        = d[54];
        return r;
    endfunction

    function automatic string result_text(t_result r);
        return {$sformatf("pc=%03h i=%04h rw=%0b x=%0h v=%02h fw=%0b f=%0b",
                          r.next_pc, r.index_value, r.reg_write_valid, r.reg_write_index,
                          r.reg_write_value, r.flag_write_valid, r.flag_value),
                $sformatf(" cls=%0b dt=%0b st=%0b t=%02h unh=%0b",
                          r.clear_screen, r.delay_write, r.sound_write, r.timer_value,
                          r.unhandled)};
    endfunction

    // a return is only let through when it pops an entry that a call has written
    task automatic queue_instr(logic [15:0] op);
        int slot;
        slot = (gen_sp == 0) ? DEPTH - 1 : gen_sp - 1;
        if (op == OPC_RET && !gen_pushed[slot]) op = {OP_CALL, 12'($urandom)};
        if (op[15:12] == OP_CALL) begin
            gen_pushed[gen_sp] = 1'b1;
            gen_sp = (gen_sp + 1) % DEPTH;
        end else if (op == OPC_RET) begin
            gen_sp = slot;
        end
        pending_instrs.push_back({8'($urandom), 16'($urandom), 8'($urandom), op});
        queued_count++;
    endtask

    function automatic logic [15:0] random_instr();
        logic [15:0] op;
        op = 16'($urandom);
        case (t_op_class'(op[15:12]))
            OP_SYS: begin
                case ($urandom_range(0, 2))
                    0:       op = OPC_CLS;
                    1:       op = OPC_RET;
                    default: ;
                endcase
            end
            OP_KEY: begin
                case ($urandom_range(0, 2))
                    0:       op[7:0] = KK_SKP;
                    1:       op[7:0] = KK_SKNP;
                    default: ;
                endcase
            end
            OP_MISC: begin
                case ($urandom_range(0, 5))
                    0:       op[7:0] = KK_LD_VDT;
                    1:       op[7:0] = KK_LD_DT;
                    2:       op[7:0] = KK_LD_ST;
                    3:       op[7:0] = KK_ADD_I;
                    4:       op[7:0] = 8'h0A;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return op;
    endfunction

    task automatic queue_random_mix(int target);
        int         kind, x, y, depth;
        logic [7:0] a, b;
        while (queued_count < target) begin
            kind = $urandom_range(0, 9);
            x = $urandom_range(0, 15);
            y = $urandom_range(0, 15);
            a = 8'($urandom);
            b = 8'($urandom);
            case (kind)
                6: begin
                    // key test with mostly in-range key numbers
                    queue_instr({OP_LD_IMM, 4'(x),
                                 ($urandom_range(0, 7) == 0) ? a : 8'($urandom_range(0, 15))});
                    queue_instr({OP_KEY, 4'(x), $urandom_range(0, 1) ? KK_SKP : KK_SKNP});
                end
                7: begin
                    if ($urandom_range(0, 1)) begin
                        queue_instr({OP_LD_IMM, 4'(x), a});
                        queue_instr({$urandom_range(0, 1) ? OP_SE_IMM : OP_SNE_IMM, 4'(x),
                                     $urandom_range(0, 1) ? a : b});
                    end else begin
                        queue_instr({OP_LD_IMM, 4'(x), a});
                        queue_instr({OP_LD_IMM, 4'(y), $urandom_range(0, 1) ? a : b});
                        queue_instr({$urandom_range(0, 1) ? OP_SE_REG : OP_SNE_REG, 4'(x), 4'(y),
                                     4'($urandom)});
                    end
                end
                8: begin
                    queue_instr({OP_LD_IMM, 4'(x), a});
                    queue_instr({OP_LD_IMM, 4'(y), b});
                    queue_instr({OP_ALU, 4'(x), 4'(y),
                                 $urandom_range(0, 2) ? FLAG_OPS[$urandom_range(0, 4)]
                                                      : 4'($urandom)});
                end
                9: begin
                    // nested subroutines, now and then deep enough to wrap the stack
                    depth = ($urandom_range(0, 15) == 0) ? DEPTH + 1 : $urandom_range(1, 4);
                    repeat (depth) begin
                        queue_instr({OP_CALL, 12'($urandom)});
                        if ($urandom_range(0, 1)) queue_instr(random_instr());
                    end
                    repeat (depth) queue_instr(OPC_RET);
                end
                default: queue_instr(($urandom_range(0, 9) == 0) ? 16'($urandom) : random_instr());
            endcase
        end
    endtask

    // sender: holds each word until its transfer, idles at random outside the steady window
    always @(posedge i_clk) begin
        bit steady;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(exec_instr(s_tdata));
                instrs_sent++;
            end
            steady = instrs_sent >= 300 && instrs_sent < 450;
            if (!s_tvalid || s_tready) begin
                if (pending_instrs.size() > 0 && (steady || $urandom_range(0, 99) >= 38)) begin
                    s_tdata  <= pending_instrs.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("unexpected result: %s", result_text(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[55] !== 1'b0) begin
                        error_count++;
                        if (error_count <= MAX_SHOWN) begin
                            $display("mismatch on result %0d", results_seen);
                            $display("  expected %s", result_text(want));
                            $display("  actual   %s pad=%0b", result_text(got), m_tdata[55]);
                        end
                    end
                end
                results_seen++;
            end
            m_tready <= (results_seen >= 500 && results_seen < 650) || $urandom_range(0, 99) >= 38;
        end
    end

    initial begin
        int groups;
        // directed: flag arithmetic, x = 15, skips, keys, wraps, unhandled forms
        queue_instr(OPC_CLS);
        queue_instr(16'h60FF);
        queue_instr(16'h6101);
        queue_instr(16'h8014);
        queue_instr(16'h70FF);
        queue_instr(16'h8015);
        queue_instr(16'h8107);
        queue_instr(16'h8016);
        queue_instr(16'h801E);
        queue_instr(16'h8F14);
        queue_instr(16'h812F);
        queue_instr(16'h5017);
        queue_instr(16'h9010);
        queue_instr(16'h6220);
        queue_instr(16'hE29E);
        queue_instr(16'hE2A1);
        queue_instr(16'hBFFF);
        queue_instr(16'hAFFF);
        queue_instr(16'hF01E);
        queue_instr(16'h1FFE);
        queue_instr(16'h2FFE);
        queue_instr(OPC_RET);
        queue_instr(16'hDABC);
        queue_instr(16'hF00A);
        queue_instr(16'hF115);
        queue_instr(16'hF218);
        queue_instr(16'hF307);
        queue_random_mix(queued_count + 280);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every instruction is sent and every result so far is back
        while (pending_instrs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);

        // climb the index register past 16 bits
        queue_instr(16'hAFFF);
        queue_instr(16'h6EFF);
        repeat (245) queue_instr(16'hFE1E);
        queue_random_mix(queued_count + 250);

        while (pending_instrs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        groups = 0;
        foreach (class_hits[i]) if (class_hits[i] > 0) groups++;
        $display("checked %0d instructions from %0d of 16 opcode groups, %0d of them unhandled",
                 instrs_sent, groups, unhandled_cnt);
        $display("stack and pc wrap, index overflow and both idle patterns exercised; %0d errors",
                 error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout after %0d of %0d instructions", instrs_sent, queued_count);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
